// ----- src/tls_pkg.sv -----
// Package: shared types and constants for the traffic light sequencer.
`timescale 1ns / 1ps

package tls_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned SecW   = 7;
  localparam int unsigned LightW = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegGreenSeconds  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegYellowSeconds = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRedSeconds    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDarkThreshold = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDebounceMs    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBlinkHalfMs   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSecondMs      = 3'd6;

  // register reset values
  localparam logic [SecW-1:0]   GreenSecondsRst  = 7'd10;
  localparam logic [SecW-1:0]   YellowSecondsRst = 7'd3;
  localparam logic [SecW-1:0]   RedSecondsRst    = 7'd10;
  localparam logic [LightW-1:0] DarkThresholdRst = 12'd1000;
  localparam logic [CntW-1:0]   DebounceMsRst    = 16'd50;
  localparam logic [CntW-1:0]   BlinkHalfMsRst   = 16'd500;
  localparam logic [CntW-1:0]   SecondMsRst      = 16'd1000;

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2
  } phase_e;

  typedef struct packed {
    logic              button_level;
    logic [LightW-1:0] light_level;
  } in_t;

  typedef struct packed {
    logic            green_lamp;
    logic            yellow_lamp;
    logic            red_lamp;
    logic            blue_lamp;
    logic [SecW-1:0] count_shown;
    logic            display_blank;
  } out_t;

  typedef struct packed {
    logic [SecW-1:0]   green_seconds;
    logic [SecW-1:0]   yellow_seconds;
    logic [SecW-1:0]   red_seconds;
    logic [LightW-1:0] dark_threshold;
    logic [CntW-1:0]   debounce_ms;
    logic [CntW-1:0]   blink_half_ms;
    logic [CntW-1:0]   second_ms;
  } cfg_t;

  typedef struct packed {
    phase_e          phase;
    logic [SecW-1:0] seconds_left;
    logic [CntW-1:0] ms_in_second;
    logic [CntW-1:0] ms_since_toggle;
    logic [CntW-1:0] ms_since_press;
    logic            previous_button;
    logic            display_enabled;
    logic            blink_on;
  } state_t;

endpackage

// ----- src/tls_step.sv -----
// Next-state and result logic for one millisecond tick.
`timescale 1ns / 1ps

module tls_step (
  input  tls_pkg::state_t state_i,
  input  tls_pkg::cfg_t   cfg_i,
  input  tls_pkg::in_t    req_i,
  output tls_pkg::state_t state_o,
  output tls_pkg::out_t   res_o
);

  logic [tls_pkg::CntW-1:0] sec_inc;
  logic [tls_pkg::CntW-1:0] tog_inc;
  logic [tls_pkg::CntW-1:0] press_inc;
  logic                     press;
  logic                     step;
  logic                     night;
  logic                     toggle;

  // saturating elapsed counters
  assign sec_inc   = (state_i.ms_in_second == tls_pkg::CntMax) ?
                     state_i.ms_in_second : state_i.ms_in_second + 16'd1;
  assign tog_inc   = (state_i.ms_since_toggle == tls_pkg::CntMax) ?
                     state_i.ms_since_toggle : state_i.ms_since_toggle + 16'd1;
  assign press_inc = (state_i.ms_since_press == tls_pkg::CntMax) ?
                     state_i.ms_since_press : state_i.ms_since_press + 16'd1;

  assign press  = !req_i.button_level && state_i.previous_button &&
                  (press_inc > cfg_i.debounce_ms);
  assign step   = (sec_inc >= cfg_i.second_ms);
  assign night  = (req_i.light_level > cfg_i.dark_threshold);
  assign toggle = night && (tog_inc >= cfg_i.blink_half_ms);

  always_comb begin
    state_o                 = state_i;
    state_o.previous_button = req_i.button_level;
    state_o.display_enabled = state_i.display_enabled ^ press;
    state_o.ms_since_press  = press ? '0 : press_inc;
    state_o.ms_in_second    = step ? '0 : sec_inc;
    state_o.ms_since_toggle = toggle ? '0 : tog_inc;
    state_o.blink_on        = state_i.blink_on ^ toggle;

    if (step) begin
      if (state_i.seconds_left == '0) begin
        unique case (state_i.phase)
          tls_pkg::PH_YELLOW: begin
            state_o.phase        = tls_pkg::PH_RED;
            state_o.seconds_left = cfg_i.red_seconds;
          end
          tls_pkg::PH_RED: begin
            state_o.phase        = tls_pkg::PH_GREEN;
            state_o.seconds_left = cfg_i.green_seconds;
          end
          default: begin
            state_o.phase        = tls_pkg::PH_YELLOW;
            state_o.seconds_left = cfg_i.yellow_seconds;
          end
        endcase
      end else begin
        state_o.seconds_left = state_i.seconds_left - 7'd1;
      end
    end
  end

  always_comb begin
    res_o.green_lamp    = 1'b0;
    res_o.yellow_lamp   = 1'b0;
    res_o.red_lamp      = 1'b0;
    if (night) begin
      res_o.yellow_lamp = state_o.blink_on;
    end else begin
      unique case (state_o.phase)
        tls_pkg::PH_YELLOW: res_o.yellow_lamp = 1'b1;
        tls_pkg::PH_RED:    res_o.red_lamp    = 1'b1;
        default:            res_o.green_lamp  = 1'b1;
      endcase
    end
    res_o.blue_lamp     = !state_o.display_enabled;
    res_o.count_shown   = state_o.seconds_left;
    res_o.display_blank = night || !state_o.display_enabled;
  end

endmodule

// ----- src/traffic_light_sequencer.sv -----
// Traffic light sequencer top level: config registers, state and result register.
// An accepted request's result is registered and shown in out_res_o in the cycle after it is accepted.
// Throughput: one request per cycle; the single result register is the only buffer,
// so a request is taken whenever that register is empty or being drained.
// Reset: asynchronous, active low; registers take their defaults, phase green,
// countdown at the default green reload, result register empty.
`timescale 1ns / 1ps

module traffic_light_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tls_pkg::in_t                      in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tls_pkg::out_t                     out_res_o,
  input  logic                              cfg_we_i,
  input  logic [tls_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tls_pkg::CfgDataW-1:0]      cfg_data_i
);

  tls_pkg::cfg_t   cfg_q;
  tls_pkg::state_t state_q;
  tls_pkg::state_t state_d;
  tls_pkg::out_t   res_d;
  tls_pkg::out_t   res_q;
  logic            valid_q;
  logic            accept;

  assign in_stall_o  = valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  tls_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .req_i   (in_req_i),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_seconds  <= tls_pkg::GreenSecondsRst;
      cfg_q.yellow_seconds <= tls_pkg::YellowSecondsRst;
      cfg_q.red_seconds    <= tls_pkg::RedSecondsRst;
      cfg_q.dark_threshold <= tls_pkg::DarkThresholdRst;
      cfg_q.debounce_ms    <= tls_pkg::DebounceMsRst;
      cfg_q.blink_half_ms  <= tls_pkg::BlinkHalfMsRst;
      cfg_q.second_ms      <= tls_pkg::SecondMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tls_pkg::RegGreenSeconds:  cfg_q.green_seconds  <= cfg_data_i[tls_pkg::SecW-1:0];
        tls_pkg::RegYellowSeconds: cfg_q.yellow_seconds <= cfg_data_i[tls_pkg::SecW-1:0];
        tls_pkg::RegRedSeconds:    cfg_q.red_seconds    <= cfg_data_i[tls_pkg::SecW-1:0];
        tls_pkg::RegDarkThreshold: cfg_q.dark_threshold <= cfg_data_i[tls_pkg::LightW-1:0];
        tls_pkg::RegDebounceMs:    cfg_q.debounce_ms    <= cfg_data_i;
        tls_pkg::RegBlinkHalfMs:   cfg_q.blink_half_ms  <= cfg_data_i;
        tls_pkg::RegSecondMs:      cfg_q.second_ms      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase           <= tls_pkg::PH_GREEN;
      state_q.seconds_left    <= tls_pkg::GreenSecondsRst;
      state_q.ms_in_second    <= '0;
      state_q.ms_since_toggle <= '0;
      state_q.ms_since_press  <= '0;
      state_q.previous_button <= 1'b1;
      state_q.display_enabled <= 1'b1;
      state_q.blink_on        <= 1'b0;
      valid_q                 <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule
